### hw/rtl/assert_macros.svh
// assertion macros used by the unit rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk_i, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

### hw/rtl/chtl_pkg.sv
// package for the chained hash table lookup and insert unit
// types, defaults and codes; no dependencies
package chtl_pkg;

  localparam int unsigned NumBucketsDef  = 256;
  localparam int unsigned BucketSlotsDef = 4;
  localparam int unsigned KeyWordsDef    = 8;

  localparam logic [1:0] CfgBucketCount = 2'd0;
  localparam logic [1:0] CfgHashMult    = 2'd1;
  localparam logic [1:0] CfgKeyLength   = 2'd2;

  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StInserted = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_CNT, S_CMP, S_WR, S_KEY, S_OUT
  } state_e;

endpackage

### hw/rtl/chained_hash_table_lookup_insert_unit.sv
// chained hash table lookup and insert unit, single module; uses chtl_pkg, assert_macros.svh
// flow: each accepted word is hashed by serial modulo reduction; a word that does not end
// its key then frees the input; the last word adds a count read, key-word compares against
// each stored key, a decision, storing the words of an inserted key and loading the output
// register, which waits while the output is stalled; one item in flight at a time
// reset: slot counts cleared by a pass over all NUM_BUCKETS buckets, input stalled meanwhile
`include "assert_macros.svh"
module chained_hash_table_lookup_insert_unit
  import chtl_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS  = NumBucketsDef,
  parameter int unsigned BUCKET_SLOTS = BucketSlotsDef,
  parameter int unsigned KEY_WORDS    = KeyWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] key_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  bucket_o,
  output logic [1:0]  slot_o
);

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int unsigned CW = $clog2(BUCKET_SLOTS + 1);
  localparam int unsigned WW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned LW = $clog2(KEY_WORDS + 1);
  localparam int unsigned MW = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned PW = BW + 16;
  localparam int unsigned AW = BW + SW + WW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned RC = $clog2(PW);

  logic [8:0]  bcnt_q;
  logic [15:0] mult_q;
  logic [3:0]  klen_q;

  state_e state_q, state_d;
  logic [BW-1:0] hsum_q, hsum_d, pow_q, pow_d, bkt_q, bkt_d;
  logic [LW-1:0] widx_q, widx_d;
  logic kind_q, kind_d, lst_q, lst_d;
  logic [PW-1:0] hsrc_q, hsrc_d, psrc_q, psrc_d;
  logic [MW-1:0] hrem_q, hrem_d, prem_q, prem_d;
  logic [RC-1:0] rcnt_q, rcnt_d;
  logic [CW-1:0] sidx_q, sidx_d;
  logic [WW-1:0] cw_q, cw_d;
  logic match_q, match_d;
  logic [1:0] st_q, st_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [WW-1:0] wcnt_q, wcnt_d;
  logic clr_q;
  logic [BW-1:0] clra_q;
  logic out_vld_q;
  logic [1:0] ost_q;
  logic [BW-1:0] obkt_q;
  logic [SW-1:0] oslot_q;

  logic [15:0] pend_q [KEY_WORDS];
  logic [15:0] key_mem [DEPTH];
  logic [CW-1:0] cnt_mem [NUM_BUCKETS];
  logic [15:0] key_rd_q;
  logic [CW-1:0] cnt_rd_q;

  logic [MW-1:0] m_use;
  logic [LW-1:0] l_use;
  logic [MW:0] h_sh, h_df, p_sh, p_df;
  logic [MW-1:0] h_nx, p_nx;
  logic [CW-1:0] c_use;
  logic [LW-1:0] widx_eff, widx_inc;
  logic in_acc, out_acc, load_out, ins;
  logic key_re;
  logic [AW-1:0] key_ra;
  logic cnt_we;
  logic [BW-1:0] cnt_wa;
  logic [CW-1:0] cnt_wd;

  always_comb begin
    m_use = (bcnt_q == 9'd0) ? MW'(1) :
            (32'(bcnt_q) > NUM_BUCKETS) ? MW'(NUM_BUCKETS) : MW'(bcnt_q);
    l_use = (klen_q == 4'd0) ? LW'(1) :
            (32'(klen_q) > KEY_WORDS) ? LW'(KEY_WORDS) : LW'(klen_q);
  end

  // restoring reduction, one source bit a cycle for hash term and power
  assign h_sh = {hrem_q, hsrc_q[PW-1]};
  assign h_df = h_sh - {1'b0, m_use};
  assign h_nx = (h_sh >= {1'b0, m_use}) ? h_df[MW-1:0] : h_sh[MW-1:0];
  assign p_sh = {prem_q, psrc_q[PW-1]};
  assign p_df = p_sh - {1'b0, m_use};
  assign p_nx = (p_sh >= {1'b0, m_use}) ? p_df[MW-1:0] : p_sh[MW-1:0];

  assign c_use = (32'(cnt_rd_q) > BUCKET_SLOTS) ? CW'(BUCKET_SLOTS) : cnt_rd_q;
  assign widx_eff = (32'(widx_q) >= KEY_WORDS) ? '0 : widx_q;
  assign widx_inc = widx_eff + LW'(1);

  assign in_stall_o = clr_q || (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_vld_q && !out_stall_i;
  assign load_out = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);
  assign ins = !match_q && kind_q && (c_use < CW'(BUCKET_SLOTS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_RED;
      S_RED:  if (rcnt_q == '0) state_d = lst_q ? S_CNT : S_IDLE;
      S_CNT:  state_d = S_CMP;
      S_CMP: begin
        if (sidx_q >= c_use) state_d = S_WR;
        else if (key_rd_q == pend_q[cw_q] && LW'(cw_q) + LW'(1) >= l_use) state_d = S_WR;
      end
      S_WR:   state_d = ins ? S_KEY : S_OUT;
      S_KEY:  if (32'(wcnt_q) == KEY_WORDS - 1) state_d = S_OUT;
      S_OUT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    hsum_d = hsum_q; pow_d = pow_q; bkt_d = bkt_q; widx_d = widx_q;
    kind_d = kind_q; lst_d = lst_q; hsrc_d = hsrc_q; psrc_d = psrc_q;
    hrem_d = hrem_q; prem_d = prem_q; rcnt_d = rcnt_q;
    sidx_d = sidx_q; cw_d = cw_q; match_d = match_q; st_d = st_q; slot_d = slot_q;
    wcnt_d = wcnt_q;
    key_re = 1'b0; key_ra = '0;
    case (state_q)
      S_IDLE: if (in_acc) begin
        kind_d = kind_i;
        lst_d = (widx_inc >= l_use);
        widx_d = (widx_inc >= l_use) ? '0 : widx_inc;
        hsrc_d = PW'(pow_q) * PW'(key_word_i) + PW'(hsum_q);
        psrc_d = PW'(pow_q) * PW'(mult_q);
        hrem_d = '0; prem_d = '0;
        rcnt_d = RC'(PW - 1);
      end
      S_RED: begin
        hsrc_d = hsrc_q << 1; psrc_d = psrc_q << 1;
        hrem_d = h_nx; prem_d = p_nx;
        if (rcnt_q != '0) rcnt_d = rcnt_q - RC'(1);
        else if (lst_q) begin
          bkt_d = BW'(h_nx); hsum_d = '0; pow_d = BW'(1);
        end else begin
          hsum_d = BW'(h_nx); pow_d = BW'(p_nx);
        end
      end
      S_CNT: begin
        sidx_d = '0; cw_d = '0; match_d = 1'b0;
        key_re = 1'b1; key_ra = {bkt_q, SW'(0), WW'(0)};
      end
      S_CMP: if (sidx_q < c_use) begin
        if (key_rd_q != pend_q[cw_q]) begin
          sidx_d = sidx_q + CW'(1); cw_d = '0;
        end else if (LW'(cw_q) + LW'(1) >= l_use) begin
          match_d = 1'b1;
        end else begin
          cw_d = cw_q + WW'(1);
        end
        key_re = 1'b1;
        key_ra = {bkt_q, SW'(sidx_d), cw_d};
      end
      S_WR: begin
        st_d = StNotFound; slot_d = '0; wcnt_d = '0;
        if (match_q) begin
          st_d = StFound; slot_d = SW'(sidx_q);
        end else if (ins) begin
          st_d = StInserted; slot_d = SW'(c_use);
        end else if (kind_q) begin
          st_d = StFull;
        end
      end
      S_KEY: wcnt_d = wcnt_q + WW'(1);
      default: ;
    endcase
  end

  assign cnt_we = clr_q || (state_q == S_WR && ins);
  assign cnt_wa = clr_q ? clra_q : bkt_q;
  assign cnt_wd = clr_q ? '0 : c_use + CW'(1);

  assign out_valid_o = out_vld_q;
  assign status_o = ost_q;
  assign bucket_o = 8'(obkt_q);
  assign slot_o = 2'(oslot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; hsum_q <= '0; pow_q <= BW'(1); widx_q <= '0; bkt_q <= '0;
      kind_q <= 1'b0; lst_q <= 1'b0; hsrc_q <= '0; psrc_q <= '0;
      hrem_q <= '0; prem_q <= '0; rcnt_q <= '0;
      sidx_q <= '0; cw_q <= '0; match_q <= 1'b0; st_q <= StNotFound; slot_q <= '0;
      wcnt_q <= '0; clr_q <= 1'b1; clra_q <= '0;
      out_vld_q <= 1'b0; ost_q <= StNotFound; obkt_q <= '0; oslot_q <= '0;
      bcnt_q <= 9'd256; mult_q <= 16'd31; klen_q <= 4'd8;
    end else begin
      state_q <= state_d; hsum_q <= hsum_d; pow_q <= pow_d; widx_q <= widx_d;
      bkt_q <= bkt_d; kind_q <= kind_d; lst_q <= lst_d; hsrc_q <= hsrc_d;
      psrc_q <= psrc_d; hrem_q <= hrem_d; prem_q <= prem_d; rcnt_q <= rcnt_d;
      sidx_q <= sidx_d; cw_q <= cw_d; match_q <= match_d; st_q <= st_d;
      slot_q <= slot_d; wcnt_q <= wcnt_d;
      if (clr_q) begin
        clra_q <= clra_q + BW'(1);
        if (32'(clra_q) == NUM_BUCKETS - 1) clr_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1; ost_q <= st_q; obkt_q <= bkt_q; oslot_q <= slot_q;
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgBucketCount: bcnt_q <= cfg_data_i[8:0];
          CfgHashMult:    mult_q <= cfg_data_i;
          CfgKeyLength:   klen_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) pend_q[WW'(widx_eff)] <= key_word_i;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_KEY)
      key_mem[{bkt_q, slot_q, wcnt_q}] <= (LW'(wcnt_q) < l_use) ? pend_q[wcnt_q] : 16'd0;
    if (key_re) key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (state_q == S_CNT) cnt_rd_q <= cnt_mem[bkt_q];
  end

  `ASSERT_CLK(a_stall_busy, (state_q != S_IDLE) |-> in_stall_o, "input taken while busy")
  `ASSERT_CLK(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) && $stable(bucket_o) && $stable(slot_o)), "result changed while stalled")
  `ASSERT_CLK(a_clr_idle, clr_q |-> (state_q == S_IDLE), "item taken during clear")

endmodule

### dv/chained_hash_table_lookup_insert_unit_test.sv
// testbench for the chained hash table lookup and insert unit
// directed table then random keys, checked against an in-bench hash table predictor
// depends on chtl_pkg and the unit rtl
`timescale 1ns / 100ps
module chained_hash_table_lookup_insert_unit_test;
  import chtl_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] bucket;
    logic [1:0] slot;
  } lookup_t;

  typedef struct {
    logic        kind;
    logic [15:0] word;
    logic        chk;
    logic [1:0]  status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CfgBucketCount;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        kind_i = 1'b0;
  logic [15:0] key_word_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o, out_valid_o;
  logic [1:0]  status_o, slot_o;
  logic [7:0]  bucket_o;

  chained_hash_table_lookup_insert_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  int unsigned m_reg = 256, p_reg = 31, k_reg = 8;
  int unsigned widx = 0, hsum = 0, pw = 1;
  logic [15:0] pend [8];
  logic [2:0]  slot_cnt [256];
  logic [15:0] keys [256][4][8];

  lookup_t expected_q[$];
  logic    has_chk_q[$];
  logic [1:0] chk_q[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit rand_out = 1'b0;
  logic [15:0] key_pool [16][8];

  function automatic void hash_word(input logic kind, input logic [15:0] w,
                                    input bit chk, input logic [1:0] cst);
    int unsigned m, kl, b, cnt;
    lookup_t r;
    bit hit;
    m = (m_reg == 0) ? 1 : (m_reg > 256 ? 256 : m_reg);
    kl = (k_reg == 0) ? 1 : (k_reg > 8 ? 8 : k_reg);
    if (widx >= 8) widx = 0;
    pend[widx] = w;
    hsum = 32'((longint'(hsum) + (longint'(pw) * w) % m) % m);
    pw = 32'((longint'(pw) * p_reg) % m);
    widx++;
    if (widx < kl) return;
    b = hsum % m;
    widx = 0; hsum = 0; pw = 1;
    cnt = slot_cnt[b] > 4 ? 4 : slot_cnt[b];
    r.status = StNotFound; r.bucket = b[7:0]; r.slot = '0;
    for (int s = 0; s < cnt; s++) begin
      hit = 1'b1;
      for (int i = 0; i < kl; i++) if (keys[b][s][i] != pend[i]) hit = 1'b0;
      if (hit) begin
        r.status = StFound; r.slot = s[1:0]; break;
      end
    end
    if (r.status != StFound && kind) begin
      if (cnt < 4) begin
        for (int i = 0; i < 8; i++) keys[b][cnt][i] = (i < kl) ? pend[i] : 16'h0;
        slot_cnt[b] = 3'(cnt + 1);
        r.status = StInserted; r.slot = cnt[1:0];
      end else begin
        r.status = StFull; r.slot = '0;
      end
    end
    expected_q.push_back(r);
    has_chk_q.push_back(chk);
    chk_q.push_back(cst);
  endfunction

  task automatic send_word(input logic kind, input logic [15:0] w,
                           input bit chk = 0, input logic [1:0] cst = StFound);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    key_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hash_word(kind, w, chk, cst);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgBucketCount: m_reg = val[8:0];
      CfgHashMult:    p_reg = val;
      default:        k_reg = val[3:0];
    endcase
  endtask

  task automatic send_key(input logic kind, input int kl, input int pick);
    for (int i = 0; i < kl; i++)
      send_word((i == kl - 1) ? kind : logic'($urandom_range(0, 1)),
                pick >= 0 ? key_pool[pick][i] : 16'($urandom));
  endtask

  // output side stall
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (rand_out) out_stall_i <= ($urandom_range(0, 3) == 0) ||
                                      ($urandom_range(0, 60) == 0);
    else out_stall_i <= 1'b0;
  end

  // checker
  always @(posedge clk_i) begin
    lookup_t e;
    logic c;
    logic [1:0] cs;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result status %0d bucket %0d slot %0d",
                 $time, status_o, bucket_o, slot_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        c = has_chk_q.pop_front();
        cs = chk_q.pop_front();
        if (c && cs != status_o) begin
          $display("%0t table status expected %0d actual %0d", $time, cs, status_o);
          errors++;
        end
        if (e.status != status_o) begin
          $display("%0t status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (e.bucket != bucket_o) begin
          $display("%0t bucket expected %0d actual %0d", $time, e.bucket, bucket_o);
          errors++;
        end
        if (e.slot != slot_o) begin
          $display("%0t slot expected %0d actual %0d", $time, e.slot, slot_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  row_t dir_rows [$];
  int cnt_items;

  initial begin
    foreach (slot_cnt[i]) slot_cnt[i] = 0;
    foreach (keys[b, s, w]) keys[b][s][w] = 0;
    foreach (pend[i]) pend[i] = 0;
    foreach (key_pool[i, j]) key_pool[i][j] = 16'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single-word keys in one bucket, modulus 1
    write_reg(CfgKeyLength, 16'd1);
    write_reg(CfgBucketCount, 16'd1);
    dir_rows = '{
      '{1'b0, 16'h0000, 1'b1, StNotFound},
      '{1'b1, 16'h0000, 1'b1, StInserted},
      '{1'b0, 16'h0000, 1'b1, StFound},
      '{1'b1, 16'hFFFF, 1'b1, StInserted},
      '{1'b1, 16'hAAAA, 1'b1, StInserted},
      '{1'b1, 16'h5555, 1'b1, StInserted},
      '{1'b1, 16'h1234, 1'b1, StFull},
      '{1'b0, 16'h1234, 1'b1, StNotFound},
      '{1'b1, 16'hFFFF, 1'b1, StFound},
      '{1'b0, 16'h5555, 1'b1, StFound}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].word, dir_rows[i].chk, dir_rows[i].status);

    // out-of-range registers: zero modulus and zero length, too-large values
    write_reg(CfgBucketCount, 16'd0);
    write_reg(CfgKeyLength, 16'd0);
    send_word(1'b0, 16'hAAAA);
    write_reg(CfgBucketCount, 16'h01FF);
    write_reg(CfgKeyLength, 16'hF);
    write_reg(CfgHashMult, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_word(1'b1, 16'hFFFF);
    // mid-key register change
    write_reg(CfgHashMult, 16'd0);
    for (int i = 0; i < 3; i++) send_word(1'b1, 16'($urandom));
    write_reg(CfgKeyLength, 16'd2);
    send_word(1'b1, 16'h8001);

    // receiver holds off while the sender keeps going
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_word(1'b1, 16'($urandom));
    join

    rand_out = 1'b1;
    cnt_items = 0;
    while (cnt_items < 1900) begin
      int kl, m;
      case ($urandom_range(0, 5))
        0: m = 1;
        1: m = 256;
        default: m = $urandom_range(2, 12);
      endcase
      write_reg(CfgBucketCount, 16'(m));
      write_reg(CfgHashMult, $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom));
      kl = $urandom_range(0, 3) == 0 ? 8 : $urandom_range(1, 3);
      write_reg(CfgKeyLength, 16'(kl));
      for (int j = 0; j < 40 && cnt_items < 1900; j++) begin
        send_key(logic'($urandom_range(0, 2) != 0), kl,
                 $urandom_range(0, 4) == 0 ? -1 : $urandom_range(0, 15));
        cnt_items += kl;
      end
    end
    in_valid_i <= 1'b0;

    fork
      while (expected_q.size() != 0) @(posedge clk_i);
      begin
        repeat (200000) @(posedge clk_i);
      end
    join_any
    disable fork;
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
